// ----- hw/rtl/wtm_pkg.sv -----
// ----------------------------------------------------------------------------
// Wavetable tone mixer package
// Sizes, action codes, controller states and the command and status
// structures shared by the mixer's controller and datapath.
// ----------------------------------------------------------------------------
package wtm_pkg;

   localparam int NUM_VOICES  = 4;
   localparam int TABLE_DEPTH = 1024;

   // Item field widths.
   localparam int ACTION_W = 2;
   localparam int INDEX_W  = 2;
   localparam int ADDR_W   = 10;
   localparam int SAMPLE_W = 12;
   localparam int LENGTH_W = 11;

   // Wide enough for any index, address, length or table depth in range.
   localparam int WIDE_W = 13;

   localparam int VID_W       = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int POS_W       = $clog2(TABLE_DEPTH);
   localparam int TBL_ENTRIES = NUM_VOICES * TABLE_DEPTH;
   localparam int TBL_AW      = $clog2(TBL_ENTRIES);
   localparam int CNT_W       = $clog2(NUM_VOICES + 1);
   localparam int SUM_W       = SAMPLE_W + CNT_W;
   localparam int DCNT_W      = $clog2(SUM_W);
   localparam int MAX_SAMPLE  = (2 ** SAMPLE_W) - 1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_SET   = 2'd2,
      ACT_SYNC  = 2'd3
   } wtm_action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DIV,
      ST_LOAD
   } wtm_state_type;

   typedef struct packed {
      logic             item_take;
      logic             clear;
      logic             rd_en;
      logic [VID_W-1:0] rd_voice;
      logic             acc_en;
      logic             div_init;
      logic             div_step;
      logic             load;
   } wtm_cmd_type;

   typedef struct packed {
      logic count_zero;
   } wtm_status_type;

endpackage

// ----- hw/rtl/wtm_if.sv -----
// ----------------------------------------------------------------------------
// Wavetable tone mixer channels
// Valid/ready channels for request items and mix result items.
// ----------------------------------------------------------------------------
interface wtm_req_if import wtm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [INDEX_W-1:0]  tone_index;
   logic [ADDR_W-1:0]   sample_address;
   logic [SAMPLE_W-1:0] sample_value;
   logic                tone_defined;
   logic                tone_enabled;
   logic [LENGTH_W-1:0] tone_length;

   modport source (
      output valid, action, tone_index, sample_address, sample_value,
             tone_defined, tone_enabled, tone_length,
      input  ready
   );
   modport sink (
      input  valid, action, tone_index, sample_address, sample_value,
             tone_defined, tone_enabled, tone_length,
      output ready
   );
endinterface

interface wtm_rsp_if import wtm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] mix_sample;

   modport source (
      output valid, mix_sample,
      input  ready
   );
   modport sink (
      input  valid, mix_sample,
      output ready
   );
endinterface

// ----- hw/rtl/wtm_ctrl.sv -----
// ----------------------------------------------------------------------------
// Wavetable tone mixer controller
// Sequences a tick through the voice walk, the divide and the result load,
// and owns both channel handshakes.
// ----------------------------------------------------------------------------
module wtm_ctrl import wtm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [ACTION_W-1:0] req_action,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output wtm_cmd_type         cmd,
   input  wtm_status_type      status
);

   wtm_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  vcnt_ff, vcnt_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              take;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign take      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vcnt_ff      <= '0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcnt_ff      <= vcnt_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      vcnt_in      = vcnt_ff;
      dcnt_in      = dcnt_ff;
      cmd          = '0;
      cmd.rd_voice = VID_W'(vcnt_ff);
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            cmd.item_take = take;
            if (take && (req_action == ACT_TICK)) begin
               cmd.clear = 1'b1;
               vcnt_in   = '0;
               state_in  = ST_WALK;
            end
         end
         ST_WALK: begin
            // Read voice n while the sample of voice n-1 is accumulated.
            cmd.rd_en  = (vcnt_ff < CNT_W'(NUM_VOICES));
            cmd.acc_en = (vcnt_ff != '0);
            vcnt_in    = vcnt_ff + 1'b1;
            if (vcnt_ff == CNT_W'(NUM_VOICES)) begin
               vcnt_in  = '0;
               state_in = ST_DIV;
               dcnt_in  = DCNT_W'(SUM_W - 1);
               cmd.div_init = 1'b1;
            end
         end
         ST_DIV: begin
            // With no enabled voice there is nothing to divide.
            if (status.count_zero) begin
               state_in = ST_LOAD;
            end else begin
               cmd.div_step = 1'b1;
               dcnt_in      = dcnt_ff - 1'b1;
               if (dcnt_ff == '0) begin
                  dcnt_in  = '0;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_tick_starts_walk: assert property (@(posedge clock) disable iff (reset)
      take && (req_action == ACT_TICK) |=> (state_ff == ST_WALK))
      else $error("tick item did not start the voice walk");

   a_load_into_free_output: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid_ff || rsp_ready))
      else $error("mix loaded over an untaken result");

   a_divide_counts_down: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step && (dcnt_ff != '0) |=>
         (state_ff == ST_DIV) && (dcnt_ff == $past(dcnt_ff) - 1'b1))
      else $error("divide step counter broke sequence");

endmodule

// ----- hw/rtl/wtm_datapath.sv -----
// ----------------------------------------------------------------------------
// Wavetable tone mixer datapath
// Voice state, the wavetable memory, the sample accumulator and a
// restoring divider that retires one quotient bit per step.
// ----------------------------------------------------------------------------
module wtm_datapath import wtm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  wtm_cmd_type         cmd,
   output wtm_status_type      status,
   input  logic [ACTION_W-1:0] action,
   input  logic [INDEX_W-1:0]  tone_index,
   input  logic [ADDR_W-1:0]   sample_address,
   input  logic [SAMPLE_W-1:0] sample_value,
   input  logic                tone_defined,
   input  logic                tone_enabled,
   input  logic [LENGTH_W-1:0] tone_length,
   output logic [SAMPLE_W-1:0] mix_sample
);

   logic [SAMPLE_W-1:0] table_mem [TBL_ENTRIES];
   logic [SAMPLE_W-1:0] rd_data_ff;

   logic [POS_W-1:0]    pos_ff [NUM_VOICES];
   logic [POS_W-1:0]    pos_in [NUM_VOICES];
   logic [LENGTH_W-1:0] len_ff [NUM_VOICES];
   logic [LENGTH_W-1:0] len_in [NUM_VOICES];
   logic [NUM_VOICES-1:0] def_ff, def_in;
   logic [NUM_VOICES-1:0] en_ff, en_in;
   logic [NUM_VOICES-1:0] pend_ff, pend_in;

   logic                take_ff, zero_ff;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [SAMPLE_W-1:0] mix_ff, mix_in;

   logic [VID_W-1:0]    wr_voice;
   logic                voice_ok, addr_ok, wr_en;
   logic [TBL_AW-1:0]   wr_addr, rd_addr;

   logic [WIDE_W-1:0]   len_lim, pos_next;
   logic [POS_W-1:0]    pos_start, pos_adv;
   logic                len_zero;
   logic [CNT_W:0]      shifted;
   logic                quo_bit;

   assign wr_voice = VID_W'(tone_index);
   assign voice_ok = WIDE_W'(tone_index) < WIDE_W'(NUM_VOICES);
   assign addr_ok  = WIDE_W'(sample_address) < WIDE_W'(TABLE_DEPTH);
   assign wr_en    = cmd.item_take && (action == ACT_WRITE) && voice_ok && addr_ok;
   assign wr_addr  = TBL_AW'(wr_voice) * TBL_AW'(TABLE_DEPTH) + TBL_AW'(sample_address);

   // Position and wrap of the voice being walked. A length above the table
   // depth wraps as the depth; a pending restart reads from entry zero.
   always_comb begin
      len_lim   = WIDE_W'(len_ff[cmd.rd_voice]);
      if (len_lim > WIDE_W'(TABLE_DEPTH)) begin
         len_lim = WIDE_W'(TABLE_DEPTH);
      end
      len_zero  = (len_lim == '0);
      pos_start = pend_ff[cmd.rd_voice] ? '0 : pos_ff[cmd.rd_voice];
      pos_next  = WIDE_W'(pos_start) + 1'b1;
      pos_adv   = (pos_next >= len_lim) ? '0 : POS_W'(pos_next);
   end

   assign rd_addr = TBL_AW'(cmd.rd_voice) * TBL_AW'(TABLE_DEPTH) + TBL_AW'(pos_start);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= sample_value;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   always_comb begin
      pos_in  = pos_ff;
      len_in  = len_ff;
      def_in  = def_ff;
      en_in   = en_ff;
      pend_in = pend_ff;
      if (cmd.item_take && (action == ACT_SET) && voice_ok) begin
         def_in[wr_voice] = tone_defined;
         en_in[wr_voice]  = tone_enabled;
         len_in[wr_voice] = tone_length;
      end
      if (cmd.item_take && (action == ACT_SYNC)) begin
         pend_in = pend_ff | def_ff;
      end
      if (cmd.rd_en && def_ff[cmd.rd_voice]) begin
         pend_in[cmd.rd_voice] = 1'b0;
         pos_in[cmd.rd_voice]  = len_zero ? '0 : pos_adv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_VOICES; i++) begin
            pos_ff[i] <= '0;
            len_ff[i] <= '0;
         end
         def_ff  <= '0;
         en_ff   <= '0;
         pend_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         len_ff  <= len_in;
         def_ff  <= def_in;
         en_ff   <= en_in;
         pend_ff <= pend_in;
      end
   end

   // Accumulator and restoring divider share the sum register: the
   // quotient bits shift in at the bottom as the dividend leaves the top.
   always_comb begin
      shifted = {rem_ff, sum_ff[SUM_W-1]};
      quo_bit = (shifted >= {1'b0, cnt_ff});
      sum_in  = sum_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      mix_in  = mix_ff;
      if (cmd.clear) begin
         sum_in = '0;
         cnt_in = '0;
      end
      if (cmd.acc_en && take_ff) begin
         sum_in = sum_ff + (zero_ff ? '0 : SUM_W'(rd_data_ff));
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.div_init) begin
         rem_in = '0;
      end
      if (cmd.div_step) begin
         rem_in = quo_bit ? CNT_W'(shifted - {1'b0, cnt_ff}) : CNT_W'(shifted);
         sum_in = {sum_ff[SUM_W-2:0], quo_bit};
      end
      if (cmd.load && (cnt_ff != '0)) begin
         mix_in = SAMPLE_W'(sum_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_ff  <= '0;
         cnt_ff  <= '0;
         take_ff <= 1'b0;
      end else begin
         mix_ff  <= mix_in;
         cnt_ff  <= cnt_in;
         take_ff <= cmd.rd_en && def_ff[cmd.rd_voice] && en_ff[cmd.rd_voice];
      end
      sum_ff  <= sum_in;
      rem_ff  <= rem_in;
      zero_ff <= len_zero;
   end

   assign status.count_zero = (cnt_ff == '0);
   assign mix_sample        = mix_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(NUM_VOICES))
      else $error("enabled voice count above voice total");

   a_remainder_below_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (rem_ff < cnt_ff))
      else $error("divider remainder not below divisor");

   a_mix_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load && (cnt_ff != '0) |-> (sum_ff <= SUM_W'(MAX_SAMPLE)))
      else $error("average exceeds sample range");

endmodule

// ----- hw/rtl/wavetable_tone_mixer.sv -----
// ----------------------------------------------------------------------------
// Wavetable tone mixer
// Top level: request and result channels around the controller and datapath.
// ----------------------------------------------------------------------------
// Table writes, voice settings and syncs are taken in the idle state and leave
// the controller there. A tick walks the voices through the single read port
// of the wavetable memory, one voice per cycle, then divides the sum by the
// enabled count in a restoring divider that retires one bit per cycle, and
// skips the divide when no voice is enabled. The mix result sits in an output
// register, so the next item is taken while it waits.
// The wavetable has no reset: an entry must be written before a voice reads it.
module wavetable_tone_mixer import wtm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   wtm_req_if.sink          req_chan,
   wtm_rsp_if.source        rsp_chan
);

   wtm_cmd_type    cmd;
   wtm_status_type status;

   wtm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .cmd        (cmd),
      .status     (status)
   );

   wtm_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .action         (req_chan.action),
      .tone_index     (req_chan.tone_index),
      .sample_address (req_chan.sample_address),
      .sample_value   (req_chan.sample_value),
      .tone_defined   (req_chan.tone_defined),
      .tone_enabled   (req_chan.tone_enabled),
      .tone_length    (req_chan.tone_length),
      .mix_sample     (rsp_chan.mix_sample)
   );

endmodule

// ----- dv/wtm_checker.sv -----
// ----------------------------------------------------------------------------
// Wavetable tone mixer checker
// Watches the request and result channels, keeps its own copy of the voice
// tables, positions and flags, predicts the mix of every tick and compares
// each result item with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module wtm_checker import wtm_pkg::*; (
   input  logic clock,
   input  logic reset,
   wtm_req_if   req_mon,
   wtm_rsp_if   rsp_mon,
   output int   failures,
   output int   pending,
   output int   checked
);

   logic [SAMPLE_W-1:0]   voice_table [NUM_VOICES][TABLE_DEPTH];
   logic [POS_W-1:0]      play_pos    [NUM_VOICES];
   logic [LENGTH_W-1:0]   period_len  [NUM_VOICES];
   logic [NUM_VOICES-1:0] defined_q;
   logic [NUM_VOICES-1:0] enabled_q;
   logic [NUM_VOICES-1:0] resync_q;
   logic [SAMPLE_W-1:0]   last_mix;
   logic [SAMPLE_W-1:0]   expected_mix [$];
   int                    errors;
   int                    compared;

   task automatic report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
   endtask

   // One tick: every defined voice yields a sample and moves on, and the
   // enabled ones are averaged into the mix.
   task automatic advance_and_mix();
      int                  total;
      int                  voices;
      int                  span;
      int                  step;
      logic [SAMPLE_W-1:0] tap;
      total  = 0;
      voices = 0;
      for (int v = 0; v < NUM_VOICES; v++) begin
         if (defined_q[v]) begin
            if (resync_q[v]) begin
               resync_q[v] = 1'b0;
               play_pos[v] = '0;
            end
            span = (period_len[v] > TABLE_DEPTH) ? TABLE_DEPTH : int'(period_len[v]);
            if (span == 0) begin
               play_pos[v] = '0;
               tap         = '0;
            end else begin
               tap         = voice_table[v][play_pos[v]];
               step        = int'(play_pos[v]) + 1;
               play_pos[v] = (step >= span) ? '0 : POS_W'(step);
            end
            if (enabled_q[v]) begin
               total  += int'(tap);
               voices += 1;
            end
         end
      end
      if (voices != 0) last_mix = SAMPLE_W'(total / voices);
      expected_mix.push_back(last_mix);
   endtask

   initial begin
      errors   = 0;
      compared = 0;
      for (int v = 0; v < NUM_VOICES; v++)
         for (int a = 0; a < TABLE_DEPTH; a++)
            voice_table[v][a] = '0;
   end

   always @(posedge clock) begin
      logic [SAMPLE_W-1:0] want;
      if (reset) begin
         for (int v = 0; v < NUM_VOICES; v++) begin
            play_pos[v]   = '0;
            period_len[v] = '0;
         end
         defined_q = '0;
         enabled_q = '0;
         resync_q  = '0;
         last_mix  = '0;
         expected_mix.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_mix.size() == 0) begin
               report($sformatf("mix item 0x%03h arrived with no tick outstanding",
                                rsp_mon.mix_sample));
            end else begin
               want = expected_mix.pop_front();
               compared++;
               if (rsp_mon.mix_sample !== want)
                  report($sformatf("mix_sample 0x%03h, predicted 0x%03h",
                                   rsp_mon.mix_sample, want));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            case (wtm_action_type'(req_mon.action))
               ACT_WRITE:
                  voice_table[req_mon.tone_index][req_mon.sample_address] =
                     req_mon.sample_value;
               ACT_SET: begin
                  defined_q[req_mon.tone_index]  = req_mon.tone_defined;
                  enabled_q[req_mon.tone_index]  = req_mon.tone_enabled;
                  period_len[req_mon.tone_index] = req_mon.tone_length;
               end
               ACT_SYNC:
                  resync_q = resync_q | defined_q;
               ACT_TICK:
                  advance_and_mix();
               default: ;
            endcase
         end
      end
      failures <= errors;
      pending  <= expected_mix.size();
      checked  <= compared;
   end

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// Wavetable tone mixer testbench
// Drives directed and random table writes, voice settings, syncs and ticks
// into the mixer with random idling on both channels, keeps every voice's
// reads inside written table entries, and takes the verdict from the checker.
// ----------------------------------------------------------------------------
module tb;
   import wtm_pkg::*;

   localparam int MAX_LENGTH = (2 ** LENGTH_W) - 1;

   logic clock = 1'b0;
   logic reset;
   int   failures;
   int   pending;
   int   checked;
   bit   no_idle;
   bit   written [NUM_VOICES][TABLE_DEPTH];
   int   filled  [NUM_VOICES];
   int   action_count [4];
   int   full_voice;

   wtm_req_if req_chan();
   wtm_rsp_if rsp_chan();

   always #4 clock = ~clock;

   wavetable_tone_mixer i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   wtm_checker i_checker (
      .clock    (clock),
      .reset    (reset),
      .req_mon  (req_chan),
      .rsp_mon  (rsp_chan),
      .failures (failures),
      .pending  (pending),
      .checked  (checked)
   );

   // Mostly no gap or a short one, now and then a long one.
   function automatic int idle_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle) return 0;
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send(wtm_action_type act, int voice, int addr, int value,
                       bit def, bit en, int len);
      int gap;
      gap = idle_len();
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.action         <= act;
      req_chan.tone_index     <= INDEX_W'(voice);
      req_chan.sample_address <= ADDR_W'(addr);
      req_chan.sample_value   <= SAMPLE_W'(value);
      req_chan.tone_defined   <= def;
      req_chan.tone_enabled   <= en;
      req_chan.tone_length    <= LENGTH_W'(len);
      do @(posedge clock); while (!req_chan.ready);
      action_count[int'(act)]++;
      // Track the written prefix of each table so that a defined voice
      // never reaches an entry that holds nothing yet.
      if (act == ACT_WRITE) begin
         written[voice][addr] = 1'b1;
         while (filled[voice] < TABLE_DEPTH && written[voice][filled[voice]])
            filled[voice]++;
      end
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         int stall;
         stall = idle_len();
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   initial begin
      #20_000_000;
      $display("run timed out with %0d mix items outstanding", pending);
      $display("FAILURE");
      $finish;
   end

   initial begin
      int v;
      int addr;
      int value;
      int len;
      int pick;
      int waited;
      bit def;
      bit en;

      reset                   <= 1'b1;
      req_chan.valid          <= 1'b0;
      req_chan.action         <= ACT_TICK;
      req_chan.tone_index     <= '0;
      req_chan.sample_address <= '0;
      req_chan.sample_value   <= '0;
      req_chan.tone_defined   <= 1'b0;
      req_chan.tone_enabled   <= 1'b0;
      req_chan.tone_length    <= '0;
      no_idle = 1'b0;
      for (int i = 0; i < NUM_VOICES; i++) filled[i] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty mix, zero-length and undefined voices, sync,
      // a shortened period and a tick with nothing enabled.
      send(ACT_TICK,  0, 0,              0,          0, 0, 0);
      send(ACT_WRITE, 0, 0,              MAX_SAMPLE, 0, 0, 0);
      send(ACT_WRITE, 0, 1,              0,          0, 0, 0);
      send(ACT_WRITE, 1, 0,              MAX_SAMPLE, 0, 0, 0);
      send(ACT_WRITE, 3, TABLE_DEPTH - 1, MAX_SAMPLE, 0, 0, 0);
      send(ACT_SET,   0, 0,              0,          1, 1, 2);
      send(ACT_SET,   1, 0,              0,          1, 1, 1);
      send(ACT_SET,   2, 0,              0,          1, 1, 0);
      send(ACT_SET,   3, 0,              0,          0, 1, MAX_LENGTH);
      send(ACT_TICK,  0, 0,              0,          0, 0, 0);
      send(ACT_TICK,  0, 0,              0,          0, 0, 0);
      send(ACT_TICK,  0, 0,              0,          0, 0, 0);
      send(ACT_SYNC,  0, 0,              0,          0, 0, 0);
      send(ACT_TICK,  0, 0,              0,          0, 0, 0);
      send(ACT_SET,   0, 0,              0,          1, 1, 1);
      send(ACT_TICK,  0, 0,              0,          0, 0, 0);
      send(ACT_SET,   0, 0,              0,          1, 0, 2);
      send(ACT_SET,   1, 0,              0,          1, 0, 1);
      send(ACT_SET,   2, 0,              0,          1, 0, 0);
      send(ACT_TICK,  0, 0,              0,          0, 0, 0);
      send(ACT_SYNC,  0, 0,              0,          0, 0, 0);
      send(ACT_TICK,  0, 0,              0,          0, 0, 0);
      send(ACT_SET,   0, 0,              0,          0, 0, 0);
      drain();

      // Load one voice's whole table back to back so that the longest
      // periods can be played.
      full_voice = $urandom_range(0, NUM_VOICES - 1);
      no_idle    = 1'b1;
      for (int a = filled[full_voice]; a < TABLE_DEPTH; a++)
         send(ACT_WRITE, full_voice, a, $urandom_range(0, MAX_SAMPLE), 0, 0, 0);
      no_idle = 1'b0;
      drain();

      for (int n = 0; n < 650; n++) begin
         if (n % 100 == 0) no_idle = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 149) == 0) drain();
         pick  = $urandom_range(0, 99);
         v     = $urandom_range(0, NUM_VOICES - 1);
         addr  = $urandom_range(0, TABLE_DEPTH - 1);
         value = $urandom_range(0, MAX_SAMPLE);
         def   = $urandom_range(0, 1);
         en    = $urandom_range(0, 1);
         len   = $urandom_range(0, MAX_LENGTH);
         if (pick < 40) begin
            send(ACT_TICK, v, addr, value, def, en, len);
         end else if (pick < 75) begin
            if (filled[v] < TABLE_DEPTH && $urandom_range(0, 9) < 7) addr = filled[v];
            if ($urandom_range(0, 4) == 0) value = $urandom_range(0, 1) ? MAX_SAMPLE : 0;
            send(ACT_WRITE, v, addr, value, def, en, len);
         end else if (pick < 90) begin
            def = ($urandom_range(0, 4) != 0);
            if (def) begin
               if (filled[v] == TABLE_DEPTH && $urandom_range(0, 3) == 0)
                  len = $urandom_range(TABLE_DEPTH + 1, MAX_LENGTH);
               else if ($urandom_range(0, 4) == 0)
                  len = filled[v];
               else
                  len = $urandom_range(0, (filled[v] < 16) ? filled[v] : 16);
            end
            send(ACT_SET, v, addr, value, def, en, len);
         end else begin
            send(ACT_SYNC, v, addr, value, def, en, len);
         end
      end

      req_chan.valid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (pending != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (30) @(posedge clock);

      $display("Covered %0d ticks, %0d table writes, %0d voice settings and %0d syncs.",
               action_count[int'(ACT_TICK)], action_count[int'(ACT_WRITE)],
               action_count[int'(ACT_SET)], action_count[int'(ACT_SYNC)]);
      $display("%0d mix items compared; voice %0d played from a fully loaded table.",
               checked, full_voice);
      if (pending != 0) $display("%0d mix items never arrived", pending);
      if (failures == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/wtm_pkg.sv
hw/rtl/wtm_if.sv
hw/rtl/wtm_ctrl.sv
hw/rtl/wtm_datapath.sv
hw/rtl/wavetable_tone_mixer.sv
dv/wtm_checker.sv
dv/tb.sv
